### hw/rtl/imgscl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Image scaler package
// Field widths, register indexes, payload structs and sequencer states shared
// by the scaler modules.
// ----------------------------------------------------------------------------
package imgscl_pkg;

    localparam int X_W         = 12;
    localparam int Y_W         = 12;
    localparam int PIX_W       = 8;
    localparam int SRC_W       = 10;
    localparam int TGT_W       = 12;
    localparam int STEP_W      = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam int DEF_MAX_COLUMNS   = 512;
    localparam int DEF_MAX_ROWS      = 512;
    localparam int DEF_FRACTION_BITS = 16;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_REQUEST = 1'b1
    } op_t;

    typedef enum logic {
        MODE_NEAREST  = 1'b0,
        MODE_BILINEAR = 1'b1
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODE           = 3'd0,
        REG_SOURCE_COLUMNS = 3'd1,
        REG_SOURCE_ROWS    = 3'd2,
        REG_TARGET_COLUMNS = 3'd3,
        REG_TARGET_ROWS    = 3'd4,
        REG_STEP           = 3'd5
    } cfg_reg_t;

    localparam logic [SRC_W-1:0]  RST_SOURCE_COLUMNS = 10'd512;
    localparam logic [SRC_W-1:0]  RST_SOURCE_ROWS    = 10'd512;
    localparam logic [TGT_W-1:0]  RST_TARGET_COLUMNS = 12'd1024;
    localparam logic [TGT_W-1:0]  RST_TARGET_ROWS    = 12'd1024;
    localparam logic [STEP_W-1:0] RST_STEP           = 24'd32768;

    typedef struct packed {
        op_t               op;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [PIX_W-1:0]  pixel;
    } req_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]  out_pixel;
        logic              out_of_range;
    } rsp_item_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_item_t;

    typedef struct packed {
        mode_t              mode;
        logic [SRC_W-1:0]   source_columns;
        logic [SRC_W-1:0]   source_rows;
        logic [TGT_W-1:0]   target_columns;
        logic [TGT_W-1:0]   target_rows;
        logic [STEP_W-1:0]  step;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_POS,
        ST_COORD,
        ST_RD00,
        ST_NEAR,
        ST_RD10,
        ST_RD01,
        ST_RD11,
        ST_B11,
        ST_TOP,
        ST_BOT,
        ST_SUM,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/imgscl_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Image scaler stream channel
// Valid/ready channel carrying one payload of a configurable struct type.
// ----------------------------------------------------------------------------
interface imgscl_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hw/rtl/imgscl_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Image scaler configuration registers
// Register file written over the configuration channel, plus the last valid
// source column and row derived from the saturated source size.
// ----------------------------------------------------------------------------
module imgscl_cfg_regs import imgscl_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    localparam int COL_W      = $clog2(MAX_COLUMNS),
    localparam int ROW_W      = $clog2(MAX_ROWS)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    imgscl_stream_if.sink      cfg,
    output cfg_t               regs,
    output logic [COL_W-1:0]   last_col,
    output logic [ROW_W-1:0]   last_row
);

    localparam int CMP_C_W = (SRC_W > COL_W + 1) ? SRC_W : COL_W + 1;
    localparam int CMP_R_W = (SRC_W > ROW_W + 1) ? SRC_W : ROW_W + 1;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic [CMP_C_W-1:0] cols_ext;
    logic [CMP_C_W-1:0] cols_sat;
    logic [CMP_R_W-1:0] rows_ext;
    logic [CMP_R_W-1:0] rows_sat;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.payload.index))
                REG_MODE:           cfg_next.mode = mode_t'(cfg.payload.data[0]);
                REG_SOURCE_COLUMNS: cfg_next.source_columns = cfg.payload.data[SRC_W-1:0];
                REG_SOURCE_ROWS:    cfg_next.source_rows = cfg.payload.data[SRC_W-1:0];
                REG_TARGET_COLUMNS: cfg_next.target_columns = cfg.payload.data[TGT_W-1:0];
                REG_TARGET_ROWS:    cfg_next.target_rows = cfg.payload.data[TGT_W-1:0];
                REG_STEP:           cfg_next.step = cfg.payload.data[STEP_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode           <= MODE_BILINEAR;
            cfg_reg.source_columns <= RST_SOURCE_COLUMNS;
            cfg_reg.source_rows    <= RST_SOURCE_ROWS;
            cfg_reg.target_columns <= RST_TARGET_COLUMNS;
            cfg_reg.target_rows    <= RST_TARGET_ROWS;
            cfg_reg.step           <= RST_STEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // A source size of zero acts as one; sizes above the store saturate.
    always_comb
    begin
        cols_ext = CMP_C_W'(cfg_reg.source_columns);
        rows_ext = CMP_R_W'(cfg_reg.source_rows);
        if (cols_ext == '0)
            cols_sat = CMP_C_W'(1);
        else if (cols_ext > CMP_C_W'(MAX_COLUMNS))
            cols_sat = CMP_C_W'(MAX_COLUMNS);
        else
            cols_sat = cols_ext;
        if (rows_ext == '0)
            rows_sat = CMP_R_W'(1);
        else if (rows_ext > CMP_R_W'(MAX_ROWS))
            rows_sat = CMP_R_W'(MAX_ROWS);
        else
            rows_sat = rows_ext;
    end

    assign last_col = COL_W'(cols_sat - CMP_C_W'(1));
    assign last_row = ROW_W'(rows_sat - CMP_R_W'(1));
    assign regs     = cfg_reg;

endmodule

`default_nettype wire

### hw/rtl/imgscl_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Image scaler shared multiplier
// Unsigned multiplier with a registered product, one result per cycle.
// ----------------------------------------------------------------------------
module imgscl_mul import imgscl_pkg::*; #(
    parameter int A_W = X_W,
    parameter int B_W = STEP_W
) (
    input  wire logic               clk,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0]      prod
);

    logic [A_W+B_W-1:0] prod_reg;
    logic [A_W+B_W-1:0] prod_next;

    assign prod_next = (A_W+B_W)'(a) * (A_W+B_W)'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

### hw/rtl/imgscl_frame_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Image scaler frame store
// Single-port pixel memory addressed by {row, column}, registered read data.
// ----------------------------------------------------------------------------
module imgscl_frame_store import imgscl_pkg::*; #(
    parameter int ADDR_W = 18
) (
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [ADDR_W-1:0]  addr,
    input  wire logic [PIX_W-1:0]   wdata,
    output logic [PIX_W-1:0]        rdata
);

    logic [PIX_W-1:0] store_mem [2**ADDR_W];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            store_mem[addr] <= wdata;
        rdata_reg <= store_mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/imgscl_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Image scaler sequencer
// Steps one item at a time; requests go through position products, clamping, store
// reads and, if bilinear, the blend on the shared multiplier; holds the result.
// ----------------------------------------------------------------------------
module imgscl_seq import imgscl_pkg::*; #(
    parameter int MAX_COLUMNS   = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS      = DEF_MAX_ROWS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    localparam int COL_W   = $clog2(MAX_COLUMNS),
    localparam int ROW_W   = $clog2(MAX_ROWS),
    localparam int ADDR_W  = COL_W + ROW_W,
    localparam int MUL_A_W = (FRACTION_BITS + PIX_W > X_W) ? FRACTION_BITS + PIX_W : X_W,
    localparam int MUL_B_W = (FRACTION_BITS + 1 > STEP_W) ? FRACTION_BITS + 1 : STEP_W,
    localparam int PROD_W  = MUL_A_W + MUL_B_W
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    imgscl_stream_if.sink             req,
    imgscl_stream_if.source           rsp,
    input  cfg_t                      cfg,
    input  wire logic [COL_W-1:0]     last_col,
    input  wire logic [ROW_W-1:0]     last_row,
    output logic                      mem_we,
    output logic [ADDR_W-1:0]         mem_addr,
    output logic [PIX_W-1:0]          mem_wdata,
    input  wire logic [PIX_W-1:0]     mem_rdata,
    output logic [MUL_A_W-1:0]        mul_a,
    output logic [MUL_B_W-1:0]        mul_b,
    input  wire logic [PROD_W-1:0]    mul_prod
);

    localparam int COORD_W = (X_W > Y_W) ? X_W : Y_W;
    localparam int POS_W   = COORD_W + STEP_W;
    localparam int IPOS_W  = POS_W + 1 - FRACTION_BITS;
    localparam int BLEND_W = FRACTION_BITS + PIX_W;
    localparam int SUM_W   = 2 * FRACTION_BITS + PIX_W;
    localparam logic [FRACTION_BITS:0] ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [POS_W:0]         HALF = (POS_W + 1)'(1) << (FRACTION_BITS - 1);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    req_item_t              item_reg,       item_next;
    logic [POS_W-1:0]       px_reg,         px_next;
    logic [POS_W-1:0]       py_reg,         py_next;
    logic [COL_W-1:0]       x0_reg,         x0_next;
    logic [COL_W-1:0]       x1_reg,         x1_next;
    logic [ROW_W-1:0]       y0_reg,         y0_next;
    logic [ROW_W-1:0]       y1_reg,         y1_next;
    logic [FRACTION_BITS-1:0] w_reg,        w_next;
    logic [FRACTION_BITS-1:0] h_reg,        h_next;
    logic [SUM_W-1:0]       acc_reg,        acc_next;
    logic [BLEND_W-1:0]     top_reg,        top_next;
    logic [BLEND_W-1:0]     bot_reg,        bot_next;
    logic [PIX_W-1:0]       res_pixel_reg,  res_pixel_next;
    logic                   res_oor_reg,    res_oor_next;
    logic [PIX_W-1:0]       out_pixel_reg,  out_pixel_next;
    logic                   out_oor_reg,    out_oor_next;

    logic                   accept;
    logic                   out_load;
    logic                   out_fire;
    logic                   req_oor;
    logic                   store_hit;
    logic [POS_W:0]         round_add;
    logic [POS_W:0]         ipx_sum;
    logic [POS_W:0]         ipy_sum;
    logic [IPOS_W-1:0]      ipx;
    logic [IPOS_W-1:0]      ipy;
    logic [COL_W-1:0]       x0_sel;
    logic [ROW_W-1:0]       y0_sel;
    logic [FRACTION_BITS:0] iw;
    logic [FRACTION_BITS:0] ih;
    logic [SUM_W-1:0]       acc_sum;

    assign accept   = req.valid && req.ready;
    assign out_fire = out_valid_reg && rsp.ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);
    assign req_oor  = (item_reg.x >= cfg.target_columns) || (item_reg.y >= cfg.target_rows);
    assign store_hit = ({1'b0, item_reg.x} < (X_W + 1)'(MAX_COLUMNS))
                    && ({1'b0, item_reg.y} < (Y_W + 1)'(MAX_ROWS));

    // Nearest mode rounds the position half up before dropping the fraction.
    assign round_add = (cfg.mode == MODE_NEAREST) ? HALF : '0;
    assign ipx_sum   = {1'b0, px_reg} + round_add;
    assign ipy_sum   = {1'b0, py_reg} + round_add;
    assign ipx       = ipx_sum[POS_W:FRACTION_BITS];
    assign ipy       = ipy_sum[POS_W:FRACTION_BITS];
    assign x0_sel    = (ipx > IPOS_W'(last_col)) ? last_col : ipx[COL_W-1:0];
    assign y0_sel    = (ipy > IPOS_W'(last_row)) ? last_row : ipy[ROW_W-1:0];
    assign iw        = ONE - {1'b0, w_reg};
    assign ih        = ONE - {1'b0, h_reg};
    assign acc_sum   = acc_reg + SUM_W'(mul_prod);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (req.payload.op == OP_LOAD) ? ST_WRITE : ST_MUL_X;
            end
            ST_WRITE: state_next = ST_IDLE;
            ST_MUL_X: state_next = req_oor ? ST_DONE : ST_MUL_Y;
            ST_MUL_Y: state_next = ST_POS;
            ST_POS:   state_next = ST_COORD;
            ST_COORD: state_next = ST_RD00;
            ST_RD00:  state_next = (cfg.mode == MODE_NEAREST) ? ST_NEAR : ST_RD10;
            ST_NEAR:  state_next = ST_DONE;
            ST_RD10:  state_next = ST_RD01;
            ST_RD01:  state_next = ST_RD11;
            ST_RD11:  state_next = ST_B11;
            ST_B11:   state_next = ST_TOP;
            ST_TOP:   state_next = ST_BOT;
            ST_BOT:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs: memory port and shared multiplier operands
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = {y0_reg, x0_reg};
        mem_wdata = item_reg.pixel;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_WRITE:
            begin
                mem_we   = store_hit;
                mem_addr = {item_reg.y[ROW_W-1:0], item_reg.x[COL_W-1:0]};
            end
            ST_MUL_X:
            begin
                mul_a = MUL_A_W'(item_reg.x);
                mul_b = MUL_B_W'(cfg.step);
            end
            ST_MUL_Y:
            begin
                mul_a = MUL_A_W'(item_reg.y);
                mul_b = MUL_B_W'(cfg.step);
            end
            ST_RD00: mem_addr = {y0_reg, x0_reg};
            ST_RD10:
            begin
                mem_addr = {y0_reg, x1_reg};
                mul_a    = MUL_A_W'(mem_rdata);
                mul_b    = MUL_B_W'(iw);
            end
            ST_RD01:
            begin
                mem_addr = {y1_reg, x0_reg};
                mul_a    = MUL_A_W'(mem_rdata);
                mul_b    = MUL_B_W'(w_reg);
            end
            ST_RD11:
            begin
                mem_addr = {y1_reg, x1_reg};
                mul_a    = MUL_A_W'(mem_rdata);
                mul_b    = MUL_B_W'(iw);
            end
            ST_B11:
            begin
                mul_a = MUL_A_W'(mem_rdata);
                mul_b = MUL_B_W'(w_reg);
            end
            ST_TOP:
            begin
                mul_a = MUL_A_W'(top_reg);
                mul_b = MUL_B_W'(ih);
            end
            ST_BOT:
            begin
                mul_a = MUL_A_W'(bot_reg);
                mul_b = MUL_B_W'(h_reg);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Datapath register updates. Products land in the state after their operands.
    always_comb
    begin
        item_next      = item_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        y0_next        = y0_reg;
        y1_next        = y1_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        acc_next       = acc_reg;
        top_next       = top_reg;
        bot_next       = bot_reg;
        res_pixel_next = res_pixel_reg;
        res_oor_next   = res_oor_reg;
        out_pixel_next = out_pixel_reg;
        out_oor_next   = out_oor_reg;
        out_valid_next = out_valid_reg && !out_fire;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    item_next = req.payload;
            end
            ST_MUL_X:
            begin
                if (req_oor)
                begin
                    res_pixel_next = '0;
                    res_oor_next   = 1'b1;
                end
            end
            ST_MUL_Y: px_next = POS_W'(mul_prod);
            ST_POS:   py_next = POS_W'(mul_prod);
            ST_COORD:
            begin
                x0_next = x0_sel;
                y0_next = y0_sel;
                x1_next = (x0_sel == last_col) ? x0_sel : x0_sel + COL_W'(1);
                y1_next = (y0_sel == last_row) ? y0_sel : y0_sel + ROW_W'(1);
                w_next  = px_reg[FRACTION_BITS-1:0];
                h_next  = py_reg[FRACTION_BITS-1:0];
            end
            ST_NEAR:
            begin
                res_pixel_next = mem_rdata;
                res_oor_next   = 1'b0;
            end
            ST_RD01:  acc_next = SUM_W'(mul_prod);
            ST_RD11:  top_next = BLEND_W'(acc_sum);
            ST_B11:   acc_next = SUM_W'(mul_prod);
            ST_TOP:   bot_next = BLEND_W'(acc_sum);
            ST_BOT:   acc_next = SUM_W'(mul_prod);
            ST_SUM:
            begin
                // The weights sum to one squared, so the blend never exceeds 255.
                res_pixel_next = acc_sum[SUM_W-1 -: PIX_W];
                res_oor_next   = 1'b0;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_pixel_next = res_pixel_reg;
                    out_oor_next   = res_oor_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        x0_reg        <= x0_next;
        x1_reg        <= x1_next;
        y0_reg        <= y0_next;
        y1_reg        <= y1_next;
        w_reg         <= w_next;
        h_reg         <= h_next;
        acc_reg       <= acc_next;
        top_reg       <= top_next;
        bot_reg       <= bot_next;
        res_pixel_reg <= res_pixel_next;
        res_oor_reg   <= res_oor_next;
        out_pixel_reg <= out_pixel_next;
        out_oor_reg   <= out_oor_next;
    end

    assign req.ready                = (state_reg == ST_IDLE);
    assign rsp.valid                = out_valid_reg;
    assign rsp.payload.out_pixel    = out_pixel_reg;
    assign rsp.payload.out_of_range = out_oor_reg;

    // Only one item is in flight: no second transfer right after an accepted one.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("imgscl_seq: input taken while an item is in progress");

    // A finished result waits while the output register is still occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !rsp.ready) |=> state_reg == ST_DONE)
        else $error("imgscl_seq: stalled result overwritten");

    // A new result only appears out of the done state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("imgscl_seq: result raised outside the done state");

    // Out-of-range results always carry a zero pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_oor_reg) |-> out_pixel_reg == '0)
        else $error("imgscl_seq: out-of-range result with nonzero pixel");

endmodule

`default_nettype wire

### hw/rtl/image_scaler_nearest_bilinear_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Image scaler core
// Nearest-neighbour and bilinear scaler over an 8-bit grayscale frame store.
// ----------------------------------------------------------------------------
// Usage:
//   req carries load items (op 0, write one source pixel at x, y) and request
//   items (op 1, ask for output pixel x, y). rsp returns one result per
//   request and none per load. cfg writes the six configuration registers;
//   write it only while no item is in progress.
//   One item is worked on at a time; req is ready only between items. A load
//   writes the frame store and returns to idle. A request out of range goes
//   straight to the done state; otherwise it forms and clamps both source
//   positions, then reads one neighbour in nearest mode or reads and blends
//   four in bilinear mode. Its steps follow from the single shared multiplier,
//   which forms both source positions and all six blend products, and from the
//   single frame store port, which supplies the four neighbours one per cycle.
//   A result waits in an output register, so the next item is taken while it
//   is still pending; if the receiver stalls, the following result waits in
//   the sequencer until the register frees up.
//   Reset restores the register defaults and empties the pipeline; the frame
//   store is not cleared, so every pixel must be loaded before it is read.
// ----------------------------------------------------------------------------
module image_scaler_nearest_bilinear_core import imgscl_pkg::*; #(
    parameter int MAX_COLUMNS   = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS      = DEF_MAX_ROWS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    imgscl_stream_if.sink    req,
    imgscl_stream_if.source  rsp,
    imgscl_stream_if.sink    cfg
);

    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int ADDR_W  = COL_W + ROW_W;
    localparam int MUL_A_W = (FRACTION_BITS + PIX_W > X_W) ? FRACTION_BITS + PIX_W : X_W;
    localparam int MUL_B_W = (FRACTION_BITS + 1 > STEP_W) ? FRACTION_BITS + 1 : STEP_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    cfg_t               regs;
    logic [COL_W-1:0]   last_col;
    logic [ROW_W-1:0]   last_row;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [PIX_W-1:0]   mem_wdata;
    logic [PIX_W-1:0]   mem_rdata;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_prod;

    imgscl_cfg_regs #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .regs     (regs),
        .last_col (last_col),
        .last_row (last_row)
    );

    imgscl_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    imgscl_frame_store #(
        .ADDR_W (ADDR_W)
    ) u_frame_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    imgscl_seq #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .MAX_ROWS      (MAX_ROWS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg       (regs),
        .last_col  (last_col),
        .last_row  (last_row),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .mul_prod  (mul_prod)
    );

endmodule

`default_nettype wire
